### rtl/core/pcm_hidden_byte_embedder_macros.svh
// assertion macros for the pcm hidden byte embedder
`ifndef PCM_HIDDEN_BYTE_EMBEDDER_MACROS_SVH
`define PCM_HIDDEN_BYTE_EMBEDDER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PHBE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PHBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/phbe_pkg.sv
// shared types and constants for the pcm hidden byte embedder
package phbe_pkg;

   localparam int SAMPLE_BITS   = 24;
   localparam int BYTE_BITS     = 8;
   localparam int POS_BITS      = 4;
   localparam int PATTERN_BITS  = 23;
   localparam int WIDTH_BITS    = 5;
   localparam int FULL_SCALE    = 8388607;
   localparam int MAX_EXTRA_POS = 14;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_sample;
      logic signed [SAMPLE_BITS-1:0] right_sample;
      logic [BYTE_BITS-1:0]          left_byte;
      logic [BYTE_BITS-1:0]          right_byte;
      logic [POS_BITS-1:0]           extra_bit_pos;
      logic                          control_bit;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } rsp_type;

endpackage

### rtl/core/phbe_place.sv
// nearest in-range sample value whose low bits equal a given pattern
module phbe_place (
   input  logic signed [phbe_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [phbe_pkg::PATTERN_BITS-1:0]       pattern,
   input  logic [phbe_pkg::WIDTH_BITS-1:0]         width,
   output logic signed [phbe_pkg::SAMPLE_BITS-1:0] placed
);

   localparam int CalcBits = phbe_pkg::SAMPLE_BITS + 2;
   localparam logic signed [CalcBits-1:0] PosLimit = CalcBits'(phbe_pkg::FULL_SCALE);
   localparam logic signed [CalcBits-1:0] NegLimit = -PosLimit;

   logic [CalcBits-1:0]        step_v;
   logic [CalcBits-1:0]        mask_v;
   logic signed [CalcBits-1:0] s_ext;
   logic signed [CalcBits-1:0] floor_v;
   logic signed [CalcBits-1:0] base_raw;
   logic signed [CalcBits-1:0] base_v;
   logic signed [CalcBits-1:0] up_v;
   logic signed [CalcBits-1:0] d_lo;
   logic signed [CalcBits-1:0] d_hi;
   logic signed [CalcBits-1:0] sel_v;

   always_comb begin
      step_v   = CalcBits'(1) << width;
      mask_v   = step_v - CalcBits'(1);
      s_ext    = {{(CalcBits-phbe_pkg::SAMPLE_BITS){sample[phbe_pkg::SAMPLE_BITS-1]}}, sample};
      floor_v  = s_ext & ~mask_v;
      base_raw = floor_v | {{(CalcBits-phbe_pkg::PATTERN_BITS){1'b0}}, pattern};
      if (base_raw > s_ext) begin
         base_v = base_raw - step_v;
      end else begin
         base_v = base_raw;
      end
      up_v = base_v + step_v;
      d_lo = s_ext - base_v;
      d_hi = up_v - s_ext;
      priority if (up_v > PosLimit) begin
         sel_v = base_v;
      end else if (base_v < NegLimit) begin
         sel_v = up_v;
      end else if (d_lo <= d_hi) begin
         sel_v = base_v;
      end else begin
         sel_v = up_v;
      end
      placed = sel_v[phbe_pkg::SAMPLE_BITS-1:0];
   end

endmodule

### rtl/core/pcm_hidden_byte_embedder.sv
// pcm hidden byte embedder: top level with input and result registers
// path: input register, then result register; one sample pair per cycle while no result
// is stalled, and an empty input register still fills while a result waits
// both placements of the left sample are formed in parallel, picked by the right result bit
// reset: synchronous, active high; clears both valid flags, payload registers keep their data
module pcm_hidden_byte_embedder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  phbe_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output phbe_pkg::rsp_type rsp_data
);

   phbe_pkg::req_type req_ff, req_ff_in;
   phbe_pkg::rsp_type rsp_ff, rsp_ff_in;
   logic              req_valid_ff, req_valid_ff_in;
   logic              rsp_valid_ff, rsp_valid_ff_in;

   logic out_free;
   logic advance;
   logic accept;

   logic [phbe_pkg::POS_BITS-1:0]           xpos_sat;
   logic [phbe_pkg::WIDTH_BITS-1:0]         bit_k;
   logic [phbe_pkg::WIDTH_BITS-1:0]         left_width;
   logic [phbe_pkg::PATTERN_BITS-1:0]       right_pat;
   logic [phbe_pkg::PATTERN_BITS-1:0]       left_pat0;
   logic [phbe_pkg::PATTERN_BITS-1:0]       left_pat1;
   logic signed [phbe_pkg::SAMPLE_BITS-1:0] right_new;
   logic signed [phbe_pkg::SAMPLE_BITS-1:0] left_new0;
   logic signed [phbe_pkg::SAMPLE_BITS-1:0] left_new1;
   phbe_pkg::rsp_type                       result;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = req_valid_ff && out_free;
      req_stall = req_valid_ff && !out_free;
      accept    = req_valid && !req_stall;

      req_valid_ff_in = accept || (req_valid_ff && !out_free);
      rsp_valid_ff_in = advance || (rsp_valid_ff && rsp_stall);
      req_ff_in       = accept ? req_data : req_ff;
      rsp_ff_in       = advance ? result : rsp_ff;
   end

   always_comb begin
      if (req_ff.extra_bit_pos > phbe_pkg::POS_BITS'(phbe_pkg::MAX_EXTRA_POS)) begin
         xpos_sat = phbe_pkg::POS_BITS'(phbe_pkg::MAX_EXTRA_POS);
      end else begin
         xpos_sat = req_ff.extra_bit_pos;
      end
      bit_k      = phbe_pkg::WIDTH_BITS'(phbe_pkg::BYTE_BITS) + phbe_pkg::WIDTH_BITS'(xpos_sat);
      left_width = bit_k + phbe_pkg::WIDTH_BITS'(1);
      right_pat  = phbe_pkg::PATTERN_BITS'(req_ff.right_byte);
      left_pat0  = (phbe_pkg::PATTERN_BITS'(req_ff.control_bit) << bit_k)
                 | phbe_pkg::PATTERN_BITS'(req_ff.left_byte);
      left_pat1  = (phbe_pkg::PATTERN_BITS'(!req_ff.control_bit) << bit_k)
                 | phbe_pkg::PATTERN_BITS'(req_ff.left_byte);
      result.right_out = right_new;
      result.left_out  = right_new[bit_k] ? left_new1 : left_new0;
   end

   phbe_place u_place_right (
      .sample  (req_ff.right_sample),
      .pattern (right_pat),
      .width   (phbe_pkg::WIDTH_BITS'(phbe_pkg::BYTE_BITS)),
      .placed  (right_new)
   );

   phbe_place u_place_left0 (
      .sample  (req_ff.left_sample),
      .pattern (left_pat0),
      .width   (left_width),
      .placed  (left_new0)
   );

   phbe_place u_place_left1 (
      .sample  (req_ff.left_sample),
      .pattern (left_pat1),
      .width   (left_width),
      .placed  (left_new1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_ff_in;
         rsp_valid_ff <= rsp_valid_ff_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_ff_in;
      rsp_ff <= rsp_ff_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/phbe_checker.sv
// port-level assertions for the pcm hidden byte embedder, bound to the top level
`include "pcm_hidden_byte_embedder_macros.svh"

module phbe_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input phbe_pkg::rsp_type rsp_data
);

   `PHBE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
   `PHBE_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled without a stalled result")
   `PHBE_ASSERT_NOW(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall, 2), "result without a transfer in")
   `PHBE_ASSERT_NOW(a_out_range, clock, reset, rsp_valid, (rsp_data.left_out != 24'h800000) && (rsp_data.right_out != 24'h800000), "result sample at negative full scale")

endmodule

bind pcm_hidden_byte_embedder phbe_checker u_phbe_checker (.*);
